// ----- rtl/core/hpq_pkg.sv -----
// hpq_pkg: shared types, codes and compare function for the binary heap queue
// used by hpq_ctrl, hpq_datapath and binary_heap_priority_queue
package hpq_pkg;

    localparam int HPQ_DEF_CAPACITY = 64;
    localparam int KEY_W            = 32;
    localparam int CNT_OUT_W        = 7;
    localparam int TDATA_OUT_W      = 48;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_CHK,
        ST_DN_RR,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WSRC_X,
        WSRC_RDATA,
        WSRC_BEST
    } wsrc_t;

    typedef struct packed {
        logic    accept_push;
        logic    accept_pop;
        logic    set_stat;
        stat_t   stat_code;
        logic    load_last;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wsrc_t   wr_src;
        logic    pos_parent;
        logic    pos_best;
        logic    lkey_load;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic at_root;
        logic up_swap;
        logic left_ok;
        logic best_is_pos;
        logic out_free;
    } sts_t;

    function automatic logic ranks_above(input logic signed [KEY_W-1:0] a,
                                         input logic signed [KEY_W-1:0] b,
                                         input logic                    min_mode);
        ranks_above = min_mode ? (a < b) : (b < a);
    endfunction

endpackage

// ----- rtl/core/binary_heap_priority_queue.sv -----
// binary_heap_priority_queue: top level of the min/max binary heap queue
// depends on hpq_pkg, hpq_ctrl and hpq_datapath
//
// usage:
//   s_ channel takes one operation per beat: s_tuser is the operation
//   (0 push, 1 pop), s_tdata the signed key for a push
//   m_ channel returns one beat per operation: root key (zero when empty),
//   entry count and status (0 ok, 1 pop on empty, 2 push on full)
//   cfg channel writes heap_mode (1 min-heap, 0 max-heap); the user must write it
//   only while idle, which the block itself does not enforce
// work per operation:
//   push does one ram read and compare per level of sift-up
//   pop does two ram reads and a three-way compare per level of sift-down;
//   popping the only key does no sift-down
//   rejected operations also return a beat; one operation is worked at a time
// reset clears the count and selects min-heap; heap ram needs no clearing
// a stalled result sits in the output register; the next beat is taken
// meanwhile and its work completes, then waits until the slot frees
module binary_heap_priority_queue
    import hpq_pkg::*;
#(
    parameter int CAPACITY = HPQ_DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [KEY_W-1:0]       s_tdata,   // key_value[31:0]
    input  logic                   s_tuser,   // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // top_key[31:0], entry_count[38:32],
                                              // status[40:39], zero[47:41]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    hpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_key     (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- rtl/core/hpq_ram.sv -----
// hpq_ram: generic single write, single read port ram with registered read
// no dependencies
module hpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/hpq_ctrl.sv -----
// hpq_ctrl: sequencing state machine for push sift-up and pop sift-down
// depends on hpq_pkg
module hpq_ctrl
    import hpq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_func,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_func == FUNC_PUSH) begin
                        state_next = sts.full ? ST_DONE : ST_UP_CHK;
                    end else if (sts.empty || sts.last_one) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DN_LAST;
                    end
                end
            end
            ST_UP_CHK:  state_next = sts.at_root ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP:  state_next = sts.up_swap ? ST_UP_CHK : ST_DONE;
            ST_DN_LAST: state_next = ST_DN_CHK;
            ST_DN_CHK:  state_next = sts.left_ok ? ST_DN_RR : ST_DONE;
            ST_DN_RR:   state_next = ST_DN_CMP;
            ST_DN_CMP:  state_next = sts.best_is_pos ? ST_DONE : ST_DN_CHK;
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.set_stat = 1'b1;
                    if (s_func == FUNC_PUSH) begin
                        if (sts.full) begin
                            cmd.stat_code = STAT_FULL;
                        end else begin
                            cmd.stat_code   = STAT_OK;
                            cmd.accept_push = 1'b1;
                        end
                    end else if (sts.empty) begin
                        cmd.stat_code = STAT_EMPTY;
                    end else begin
                        cmd.stat_code  = STAT_OK;
                        cmd.accept_pop = 1'b1;
                        cmd.rd_en      = 1'b1;
                        cmd.rd_sel     = RD_LAST;
                    end
                end
            end
            ST_UP_CHK: begin
                if (sts.at_root) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = WSRC_X;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PARENT;
                end
            end
            ST_UP_CMP: begin
                cmd.wr_en = 1'b1;
                if (sts.up_swap) begin
                    cmd.wr_src     = WSRC_RDATA;
                    cmd.pos_parent = 1'b1;
                end else begin
                    cmd.wr_src = WSRC_X;
                end
            end
            ST_DN_LAST: begin
                cmd.load_last = 1'b1;
            end
            ST_DN_CHK: begin
                if (sts.left_ok) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LEFT;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = WSRC_X;
                end
            end
            ST_DN_RR: begin
                cmd.lkey_load = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_RIGHT;
            end
            ST_DN_CMP: begin
                cmd.wr_en = 1'b1;
                if (sts.best_is_pos) begin
                    cmd.wr_src = WSRC_X;
                end else begin
                    cmd.wr_src   = WSRC_BEST;
                    cmd.pos_best = 1'b1;
                end
            end
            ST_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/hpq_datapath.sv -----
// hpq_datapath: heap storage, index arithmetic, key compares and result register
// depends on hpq_pkg and hpq_ram
module hpq_datapath
    import hpq_pkg::*;
#(
    parameter int CAPACITY = HPQ_DEF_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [KEY_W-1:0]       s_key,
    input  logic                   cfg_valid,
    input  logic                   cfg_data,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic                    mode_reg;
    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           pos_reg;
    logic signed [KEY_W-1:0] x_reg;
    logic signed [KEY_W-1:0] lkey_reg;
    logic signed [KEY_W-1:0] top_reg;
    logic [1:0]              stat_reg;
    logic                    m_tvalid_reg;
    logic [TDATA_OUT_W-1:0]  m_tdata_reg;

    logic [KEY_W-1:0]        rd_data_raw;
    logic signed [KEY_W-1:0] rd_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    logic [CW-1:0]           last_idx;
    logic [AW-1:0]           parent;
    logic [IW-1:0]           pos_ext;
    logic [IW-1:0]           left;
    logic [IW-1:0]           right;
    logic [IW-1:0]           count_ext;
    logic                    right_ok;
    logic                    l_better;
    logic                    r_better;
    logic signed [KEY_W-1:0] cand_key;
    logic signed [KEY_W-1:0] best_key;
    logic [IW-1:0]           best_pos;
    logic [CW+CNT_OUT_W-1:0] cnt_wide;
    logic signed [KEY_W-1:0] top_out;

    assign rd_data   = rd_data_raw;
    assign last_idx  = count_reg - CW'(1);
    assign parent    = (pos_reg - AW'(1)) >> 1;
    assign pos_ext   = {{(IW-AW){1'b0}}, pos_reg};
    assign left      = (pos_ext << 1) + IW'(1);
    assign right     = (pos_ext << 1) + IW'(2);
    assign count_ext = {1'b0, count_reg};
    assign right_ok  = right < count_ext;

    assign l_better  = ranks_above(lkey_reg, x_reg, mode_reg);
    assign cand_key  = l_better ? lkey_reg : x_reg;
    assign r_better  = right_ok && ranks_above(rd_data, cand_key, mode_reg);
    assign best_key  = r_better ? rd_data : lkey_reg;
    assign best_pos  = r_better ? right : left;

    assign sts.full        = (count_reg == CAP_C);
    assign sts.empty       = (count_reg == '0);
    assign sts.last_one    = (count_reg == CW'(1));
    assign sts.at_root     = (pos_reg == '0);
    assign sts.up_swap     = ranks_above(x_reg, rd_data, mode_reg);
    assign sts.left_ok     = left < count_ext;
    assign sts.best_is_pos = !l_better && !r_better;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    always_comb begin
        case (cmd.rd_sel)
            RD_LAST:   rd_addr = last_idx[AW-1:0];
            RD_PARENT: rd_addr = parent;
            RD_LEFT:   rd_addr = left[AW-1:0];
            RD_RIGHT:  rd_addr = right[AW-1:0];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        case (cmd.wr_src)
            WSRC_X:     wr_data = x_reg;
            WSRC_RDATA: wr_data = rd_data;
            WSRC_BEST:  wr_data = best_key;
            default:    wr_data = x_reg;
        endcase
    end

    assign rd_en   = cmd.rd_en;
    assign wr_en   = cmd.wr_en;
    assign wr_addr = pos_reg;

    hpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b1;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (cmd.accept_push) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.accept_pop) begin
                count_reg <= last_idx;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign cnt_wide = {{CNT_OUT_W{1'b0}}, count_reg};
    assign top_out  = (count_reg == '0) ? '0 : top_reg;

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept_push) begin
            x_reg   <= s_key;
            pos_reg <= count_reg[AW-1:0];
        end else if (cmd.load_last) begin
            x_reg   <= rd_data;
            pos_reg <= '0;
        end else if (cmd.pos_parent) begin
            pos_reg <= parent;
        end else if (cmd.pos_best) begin
            pos_reg <= best_pos[AW-1:0];
        end
        if (cmd.lkey_load) begin
            lkey_reg <= rd_data;
        end
        if (cmd.set_stat) begin
            stat_reg <= cmd.stat_code;
        end
        if (wr_en && (wr_addr == '0)) begin
            top_reg <= wr_data;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{(TDATA_OUT_W-KEY_W-CNT_OUT_W-2){1'b0}}, stat_reg,
                            cnt_wide[CNT_OUT_W-1:0], top_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
